// ----- hw/rtl/irpd_pkg.sv -----
// Shared types and constants for the infrared pulse-distance transmitter.
package irpd_pkg;

    // Transmitter phase
    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_HIGH  = 2'd1,
        PH_LOW   = 2'd2,
        PH_SPACE = 2'd3
    } phase_t;

    // Entry point into the segment sequencer
    typedef enum logic [2:0] {
        GO_HIGH        = 3'd0,
        GO_LOW         = 3'd1,
        GO_PERIOD_END  = 3'd2,
        GO_SPACE_START = 3'd3,
        GO_SPACE_NEXT  = 3'd4
    } go_t;

    // Symbol kinds
    typedef enum logic [1:0] {
        SYM_START = 2'd0,
        SYM_ONE   = 2'd1,
        SYM_ZERO  = 2'd2,
        SYM_END   = 2'd3
    } symbol_t;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_ON_TICKS      = 3'd0,
        REG_OFF_TICKS     = 3'd1,
        REG_START_MARK    = 3'd2,
        REG_BIT_MARK      = 3'd3,
        REG_START_SPACE   = 3'd4,
        REG_ONE_SPACE     = 3'd5,
        REG_ZERO_SPACE    = 3'd6,
        REG_END_SPACE     = 3'd7
    } cfg_reg_t;

    // Input item command
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_LOAD = 1'b1;

    // Field widths
    localparam int CarrierW = 10;
    localparam int PeriodW  = CarrierW + 1;
    localparam int MarkW    = 8;
    localparam int SpaceW   = 16;
    localparam int AccW     = 17;

    // Register reset values (mark counts are in carrier periods of on_ticks plus off_ticks, 26 us each at reset)
    localparam logic [CarrierW-1:0] ON_TICKS_RST    = 10'd13;
    localparam logic [CarrierW-1:0] OFF_TICKS_RST   = 10'd13;
    localparam logic [MarkW-1:0]    START_MARK_RST  = 8'd129;
    localparam logic [MarkW-1:0]    BIT_MARK_RST    = 8'd17;
    localparam logic [SpaceW-1:0]   START_SPACE_RST = 16'd1725;
    localparam logic [SpaceW-1:0]   ONE_SPACE_RST   = 16'd1200;
    localparam logic [SpaceW-1:0]   ZERO_SPACE_RST  = 16'd400;
    localparam logic [SpaceW-1:0]   END_SPACE_RST   = 16'd14000;

    // Sequencer state that changes from segment to segment
    typedef struct packed {
        phase_t              phase;
        logic [PeriodW-1:0]  ticks;
        logic [MarkW-1:0]    periods;
        logic [AccW-1:0]     acc;
    } seg_state_t;

endpackage

// ----- hw/rtl/ir_pulse_distance_transmitter.sv -----
// Top level of the infrared pulse-distance transmitter.
//
// Input stream (s_axis_*): one transaction per item. tuser carries the command
// (0 one-microsecond tick, 1 load a symbol); tdata carries the symbol kind
// (0 start, 1 one, 2 zero, 3 end), used by loads only. Output stream (m_axis_*):
// one transaction per input item with the pin level for that tick, busy,
// symbol-done and rejected flags. A load while a symbol is in progress is
// rejected and leaves the state untouched.
// Configuration channel (cfg_*): register index and data, always ready; write
// only while the transmitter is idle.
// The result is registered and presented in the cycle after the input transaction.
// Throughput: one item per cycle; the next-segment logic is a single pass from
// the state registers to the result register, and the output register frees
// itself in the cycle it is taken, so input is held back only while a result
// waits and the receiver is stalling.
// Reset puts the sequencer in idle and the registers at their default timing
// (13/13 us carrier, 129 and 17 mark periods, 1725/1200/400/14000 us spaces).
module ir_pulse_distance_transmitter
(
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [1:0] symbol_kind, [7:2] zero
    input  logic        s_axis_tuser,   // [0] command
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [0] pin_level, [1] busy_res, [2] symbol_done,
                                        // [3] rejected, [7:4] zero
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    // Configuration registers
    logic [irpd_pkg::CarrierW-1:0] on_ticks_reg;
    logic [irpd_pkg::CarrierW-1:0] off_ticks_reg;
    logic [irpd_pkg::MarkW-1:0]    start_mark_reg;
    logic [irpd_pkg::MarkW-1:0]    bit_mark_reg;
    logic [irpd_pkg::SpaceW-1:0]   start_space_reg;
    logic [irpd_pkg::SpaceW-1:0]   one_space_reg;
    logic [irpd_pkg::SpaceW-1:0]   zero_space_reg;
    logic [irpd_pkg::SpaceW-1:0]   end_space_reg;

    // Sequencer state
    irpd_pkg::seg_state_t          seg_reg;
    irpd_pkg::seg_state_t          seg_next;
    irpd_pkg::symbol_t             sym_reg;
    irpd_pkg::symbol_t             sym_next;

    // Output register
    logic                          m_valid_reg;
    logic [3:0]                    m_data_reg;
    logic [3:0]                    m_data_next;

    logic                          s_accept;
    logic                          cmd;
    irpd_pkg::symbol_t             kind;
    irpd_pkg::symbol_t             space_sym;
    logic [irpd_pkg::MarkW-1:0]    load_mark;
    logic [irpd_pkg::SpaceW-1:0]   space_sel;
    logic [irpd_pkg::PeriodW-1:0]  ticks_dec;
    irpd_pkg::go_t                 seq_go;
    irpd_pkg::seg_state_t          seq_cur;
    irpd_pkg::seg_state_t          seq_nxt;
    logic                          seq_fin;
    logic                          pin;
    logic                          done;
    logic                          rej;

    assign cmd           = s_axis_tuser;
    assign kind          = irpd_pkg::symbol_t'(s_axis_tdata[1:0]);
    assign s_axis_tready = !m_valid_reg || m_axis_tready;
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {4'd0, m_data_reg};

    // Configuration register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            on_ticks_reg    <= irpd_pkg::ON_TICKS_RST;
            off_ticks_reg   <= irpd_pkg::OFF_TICKS_RST;
            start_mark_reg  <= irpd_pkg::START_MARK_RST;
            bit_mark_reg    <= irpd_pkg::BIT_MARK_RST;
            start_space_reg <= irpd_pkg::START_SPACE_RST;
            one_space_reg   <= irpd_pkg::ONE_SPACE_RST;
            zero_space_reg  <= irpd_pkg::ZERO_SPACE_RST;
            end_space_reg   <= irpd_pkg::END_SPACE_RST;
        end
        else if (cfg_valid)
        begin
            unique case (irpd_pkg::cfg_reg_t'(cfg_index))
                irpd_pkg::REG_ON_TICKS:    on_ticks_reg    <= cfg_data[9:0];
                irpd_pkg::REG_OFF_TICKS:   off_ticks_reg   <= cfg_data[9:0];
                irpd_pkg::REG_START_MARK:  start_mark_reg  <= cfg_data[7:0];
                irpd_pkg::REG_BIT_MARK:    bit_mark_reg    <= cfg_data[7:0];
                irpd_pkg::REG_START_SPACE: start_space_reg <= cfg_data;
                irpd_pkg::REG_ONE_SPACE:   one_space_reg   <= cfg_data;
                irpd_pkg::REG_ZERO_SPACE:  zero_space_reg  <= cfg_data;
                irpd_pkg::REG_END_SPACE:   end_space_reg   <= cfg_data;
                default:                   on_ticks_reg    <= on_ticks_reg;
            endcase
        end
    end

    // Sequencer inputs: a load starts a fresh symbol, a tick continues the current one
    assign load_mark = (kind == irpd_pkg::SYM_START) ? start_mark_reg : bit_mark_reg;
    assign space_sym = (cmd == irpd_pkg::CMD_LOAD) ? kind : sym_reg;
    assign ticks_dec = seg_reg.ticks - irpd_pkg::PeriodW'(seg_reg.ticks != '0);

    always_comb
    begin
        unique case (space_sym)
            irpd_pkg::SYM_START: space_sel = start_space_reg;
            irpd_pkg::SYM_ONE:   space_sel = one_space_reg;
            irpd_pkg::SYM_ZERO:  space_sel = zero_space_reg;
            irpd_pkg::SYM_END:   space_sel = end_space_reg;
            default:             space_sel = end_space_reg;
        endcase
    end

    always_comb
    begin
        seq_cur = seg_reg;
        if (cmd == irpd_pkg::CMD_LOAD)
        begin
            seq_cur.periods = load_mark;
            seq_cur.acc     = '0;
            seq_go          = (load_mark != '0) ? irpd_pkg::GO_HIGH : irpd_pkg::GO_SPACE_START;
        end
        else
        begin
            unique case (seg_reg.phase)
                irpd_pkg::PH_HIGH: seq_go = irpd_pkg::GO_LOW;
                irpd_pkg::PH_LOW:  seq_go = irpd_pkg::GO_PERIOD_END;
                default:           seq_go = irpd_pkg::GO_SPACE_NEXT;
            endcase
        end
    end

    irpd_seg u_seg
    (
        .go        (seq_go),
        .on_ticks  (on_ticks_reg),
        .off_ticks (off_ticks_reg),
        .space_us  (space_sel),
        .cur       (seq_cur),
        .nxt       (seq_nxt),
        .fin       (seq_fin)
    );

    // Next state and result for the item on the input
    always_comb
    begin
        seg_next = seg_reg;
        sym_next = sym_reg;
        pin      = 1'b0;
        done     = 1'b0;
        rej      = 1'b0;
        if (cmd == irpd_pkg::CMD_LOAD)
        begin
            if (seg_reg.phase != irpd_pkg::PH_IDLE)
            begin
                rej = 1'b1;
                pin = (seg_reg.phase == irpd_pkg::PH_HIGH);
            end
            else
            begin
                sym_next = kind;
                seg_next = seq_nxt;
                done     = seq_fin;
                pin      = (seq_nxt.phase == irpd_pkg::PH_HIGH);
            end
        end
        else if (seg_reg.phase != irpd_pkg::PH_IDLE)
        begin
            pin = (seg_reg.phase == irpd_pkg::PH_HIGH);
            if (ticks_dec == '0)
            begin
                seg_next = seq_nxt;
                done     = seq_fin;
            end
            else
            begin
                seg_next.ticks = ticks_dec;
            end
        end
        m_data_next = {rej, done, (seg_next.phase != irpd_pkg::PH_IDLE), pin};
    end

    // State update on each input transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_reg.phase   <= irpd_pkg::PH_IDLE;
            seg_reg.ticks   <= '0;
            seg_reg.periods <= '0;
            seg_reg.acc     <= '0;
            sym_reg         <= irpd_pkg::SYM_START;
        end
        else if (s_accept)
        begin
            seg_reg <= seg_next;
            sym_reg <= sym_next;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (s_accept)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            m_data_reg <= m_data_next;
        end
    end

endmodule

// ----- hw/rtl/irpd_seg.sv -----
// Segment sequencer: finds the next segment of nonzero length of a symbol.
module irpd_seg
(
    input  irpd_pkg::go_t                     go,
    input  logic [irpd_pkg::CarrierW-1:0]     on_ticks,
    input  logic [irpd_pkg::CarrierW-1:0]     off_ticks,
    input  logic [irpd_pkg::SpaceW-1:0]       space_us,
    input  irpd_pkg::seg_state_t              cur,
    output irpd_pkg::seg_state_t              nxt,
    output logic                              fin
);

    logic [irpd_pkg::PeriodW-1:0] per;
    logic [irpd_pkg::MarkW-1:0]   periods_dec;
    logic                         pend;
    logic                         sstart;
    logic                         snext;

    assign per         = {1'b0, on_ticks} + {1'b0, off_ticks};
    assign periods_dec = cur.periods - irpd_pkg::MarkW'(cur.periods != '0);

    // Walk the segment order: high, low, period end, space start, further space chunks
    always_comb
    begin
        nxt.phase   = irpd_pkg::PH_IDLE;
        nxt.ticks   = '0;
        nxt.periods = cur.periods;
        nxt.acc     = cur.acc;
        fin         = 1'b0;
        pend        = 1'b0;
        sstart      = 1'b0;
        snext       = 1'b0;

        unique case (go)
            irpd_pkg::GO_HIGH:
            begin
                if (on_ticks != '0)
                begin
                    nxt.phase = irpd_pkg::PH_HIGH;
                    nxt.ticks = {1'b0, on_ticks};
                end
                else if (off_ticks != '0)
                begin
                    nxt.phase = irpd_pkg::PH_LOW;
                    nxt.ticks = {1'b0, off_ticks};
                end
                else
                begin
                    pend = 1'b1;
                end
            end
            irpd_pkg::GO_LOW:
            begin
                if (off_ticks != '0)
                begin
                    nxt.phase = irpd_pkg::PH_LOW;
                    nxt.ticks = {1'b0, off_ticks};
                end
                else
                begin
                    pend = 1'b1;
                end
            end
            irpd_pkg::GO_PERIOD_END:  pend   = 1'b1;
            irpd_pkg::GO_SPACE_START: sstart = 1'b1;
            irpd_pkg::GO_SPACE_NEXT:  snext  = 1'b1;
            default:                  fin    = 1'b1;
        endcase

        // End of a carrier period; an all-zero carrier drains the mark at once
        if (pend)
        begin
            nxt.periods = periods_dec;
            if (periods_dec != '0 && on_ticks != '0)
            begin
                nxt.phase = irpd_pkg::PH_HIGH;
                nxt.ticks = {1'b0, on_ticks};
            end
            else if (periods_dec != '0 && off_ticks != '0)
            begin
                nxt.phase = irpd_pkg::PH_LOW;
                nxt.ticks = {1'b0, off_ticks};
            end
            else
            begin
                sstart = 1'b1;
            end
        end

        // First space chunk is on_ticks long and counts as a whole period
        if (sstart)
        begin
            if (space_us == '0 || per == '0)
            begin
                fin = 1'b1;
            end
            else
            begin
                nxt.acc = irpd_pkg::AccW'(per);
                if (on_ticks != '0)
                begin
                    nxt.phase = irpd_pkg::PH_SPACE;
                    nxt.ticks = {1'b0, on_ticks};
                end
                else
                begin
                    snext = 1'b1;
                end
            end
        end

        // Further full periods while the accumulated space is short of the request
        if (snext)
        begin
            if (per != '0 && nxt.acc < irpd_pkg::AccW'(space_us))
            begin
                nxt.acc   = nxt.acc + irpd_pkg::AccW'(per);
                nxt.phase = irpd_pkg::PH_SPACE;
                nxt.ticks = per;
            end
            else
            begin
                fin = 1'b1;
            end
        end

        // Symbol finished: back to idle
        if (fin)
        begin
            nxt.phase   = irpd_pkg::PH_IDLE;
            nxt.ticks   = '0;
            nxt.periods = '0;
            nxt.acc     = '0;
        end
    end

endmodule
